/* rtl/lppu_pkg.sv */
// ----------------------------------------------------------------------------
// lppu_pkg
// Shared types and constants for the lossless pixel prediction undo core.
// ----------------------------------------------------------------------------
package lppu_pkg;

  localparam int unsigned SampleW     = 12;
  localparam int unsigned LineWidthW  = 13;
  localparam int unsigned SampleBitsW = 4;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 13;
  localparam int unsigned ModeW       = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgLineWidth       = 2'd0,
    CfgSampleBits      = 2'd1,
    CfgFieldInterleave = 2'd2
  } cfg_idx_e;

  typedef enum logic [ModeW-1:0] {
    PredNone     = 2'd0,
    PredLeft     = 2'd1,
    PredGradient = 2'd2,
    PredMedian   = 2'd3
  } pred_mode_e;

  // Per-item control passed from the address stage to reconstruction.
  typedef struct packed {
    pred_mode_e mode;
    logic       col_zero;
    logic       vertical;
    logic       first;
  } lppu_info_t;

endpackage

/* rtl/lossless_pixel_prediction_undo_core.sv */
// ----------------------------------------------------------------------------
// lossless_pixel_prediction_undo_core
// Rebuilds pixels of one plane slice from left, gradient or median residuals.
// Items pass a stage-1 register, then an output register. Throughput: one
// item per cycle unless the output stalls, set by the single read and single
// write port of the line store, read one item ahead of reconstruction.
// Reset clears the position, mode and pipeline state and the registers to
// their defaults; the line store is not cleared and is read only once written.
// ----------------------------------------------------------------------------
module lossless_pixel_prediction_undo_core
  import lppu_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [15:0]         s_axis_tdata,   // residual[11:0], zero pad
  input  logic [2:0]          s_axis_tuser,   // first_of_slice[0], pred_mode[2:1]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [15:0]         m_axis_tdata,   // pixel[11:0], zero pad
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned AddrW = $clog2(MAX_WIDTH) + 1;

  logic [LineWidthW-1:0]  line_width_q;
  logic [SampleBitsW-1:0] sample_bits_q;
  logic                   field_il_q;

  logic [SampleBitsW-1:0] bits;
  logic [SampleW-1:0]     mask;
  logic                   accept;
  logic [AddrW-1:0]       raddr, waddr_in, wr_addr;
  lppu_info_t             info;
  logic [SampleW-1:0]     top, wr_data, pixel;
  logic                   wr_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q  <= LineWidthW'(4096);
      sample_bits_q <= SampleBitsW'(10);
      field_il_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgLineWidth:       line_width_q  <= cfg_wdata_i[LineWidthW-1:0];
        CfgSampleBits:      sample_bits_q <= cfg_wdata_i[SampleBitsW-1:0];
        CfgFieldInterleave: field_il_q    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign bits = (sample_bits_q > SampleBitsW'(SampleW)) ? SampleBitsW'(SampleW) : sample_bits_q;
  assign mask = SampleW'((13'd1 << bits) - 13'd1);

  assign accept = s_axis_tvalid && s_axis_tready;

  lppu_addr_gen #(
    .MaxWidth (MAX_WIDTH)
  ) u_addr_gen (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .accept_i           (accept),
    .first_i            (s_axis_tuser[0]),
    .mode_i             (s_axis_tuser[2:1]),
    .line_width_i       (line_width_q),
    .field_interleave_i (field_il_q),
    .raddr_o            (raddr),
    .waddr_o            (waddr_in),
    .info_o             (info)
  );

  lppu_line_mem #(
    .AddrW (AddrW)
  ) u_line_mem (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (accept),
    .raddr_i (raddr),
    .rdata_o (top)
  );

  lppu_recon #(
    .AddrW (AddrW)
  ) u_recon (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .residual_i  (s_axis_tdata[SampleW-1:0]),
    .info_i      (info),
    .waddr_i     (waddr_in),
    .top_i       (top),
    .mask_i      (mask),
    .ready_o     (s_axis_tready),
    .we_o        (wr_en),
    .waddr_o     (wr_addr),
    .wdata_o     (wr_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .pixel_o     (pixel)
  );

  assign m_axis_tdata = {4'b0000, pixel};

endmodule

/* rtl/lppu_line_mem.sv */
// ----------------------------------------------------------------------------
// lppu_line_mem
// Two-row line store: one write port, one registered read port. A read of
// the entry written in the same cycle returns the new value.
// ----------------------------------------------------------------------------
module lppu_line_mem
  import lppu_pkg::*;
#(
  parameter int unsigned AddrW = 13
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [AddrW-1:0]   waddr_i,
  input  logic [SampleW-1:0] wdata_i,
  input  logic               re_i,
  input  logic [AddrW-1:0]   raddr_i,
  output logic [SampleW-1:0] rdata_o
);

  localparam int unsigned Depth = 2 ** AddrW;

  logic [SampleW-1:0] mem [Depth];
  logic [SampleW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/lppu_addr_gen.sv */
// ----------------------------------------------------------------------------
// lppu_addr_gen
// Raster position tracking: column, finished rows and row slot, giving the
// line store addresses and the control of each accepted item.
// ----------------------------------------------------------------------------
module lppu_addr_gen
  import lppu_pkg::*;
#(
  parameter int unsigned MaxWidth = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic                          first_i,
  input  logic [ModeW-1:0]              mode_i,
  input  logic [LineWidthW-1:0]         line_width_i,
  input  logic                          field_interleave_i,
  output logic [$clog2(MaxWidth):0]     raddr_o,
  output logic [$clog2(MaxWidth):0]     waddr_o,
  output lppu_info_t                    info_o
);

  localparam int unsigned ColW = $clog2(MaxWidth);
  localparam int unsigned CmpW = (ColW + 1 > LineWidthW) ? ColW + 1 : LineWidthW;

  logic [ColW-1:0]   column_q, column_d;
  logic [1:0]        rows_q, rows_d;
  logic              slot_q, slot_d;
  pred_mode_e        mode_q, mode_d;

  logic [ColW-1:0]   cur_col;
  logic [1:0]        cur_rows;
  logic              cur_slot;
  logic              vertical;
  logic              src_slot;
  logic [CmpW-1:0]   lw_ext;
  logic [CmpW-1:0]   eff_width;
  logic [CmpW-1:0]   next_col;

  always_comb begin
    cur_col  = first_i ? '0 : column_q;
    cur_rows = first_i ? 2'd0 : rows_q;
    cur_slot = first_i ? 1'b0 : slot_q;
    mode_d   = first_i ? pred_mode_e'(mode_i) : mode_q;

    vertical = field_interleave_i ? (cur_rows == 2'd2) : (cur_rows != 2'd0);
    src_slot = field_interleave_i ? cur_slot : ~cur_slot;

    lw_ext = CmpW'(line_width_i);
    if (lw_ext == '0) begin
      eff_width = CmpW'(1);
    end else if (lw_ext > CmpW'(MaxWidth)) begin
      eff_width = CmpW'(MaxWidth);
    end else begin
      eff_width = lw_ext;
    end

    next_col = CmpW'(cur_col) + CmpW'(1);
    if (next_col >= eff_width) begin
      column_d = '0;
      rows_d   = (cur_rows == 2'd2) ? 2'd2 : cur_rows + 2'd1;
      slot_d   = ~cur_slot;
    end else begin
      column_d = next_col[ColW-1:0];
      rows_d   = cur_rows;
      slot_d   = cur_slot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q <= '0;
      rows_q   <= 2'd0;
      slot_q   <= 1'b0;
      mode_q   <= PredNone;
    end else if (accept_i) begin
      column_q <= column_d;
      rows_q   <= rows_d;
      slot_q   <= slot_d;
      mode_q   <= mode_d;
    end
  end

  assign raddr_o = {src_slot, cur_col};
  assign waddr_o = {cur_slot, cur_col};

  assign info_o.mode     = mode_d;
  assign info_o.col_zero = (cur_col == '0);
  assign info_o.vertical = vertical;
  assign info_o.first    = first_i;

endmodule

/* rtl/lppu_recon.sv */
// ----------------------------------------------------------------------------
// lppu_recon
// Reconstruction stage: forms the prediction from left, top and top-left,
// adds the residual, writes the pixel back and holds it for the output.
// ----------------------------------------------------------------------------
module lppu_recon
  import lppu_pkg::*;
#(
  parameter int unsigned AddrW = 13
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  logic [SampleW-1:0] residual_i,
  input  lppu_info_t         info_i,
  input  logic [AddrW-1:0]   waddr_i,
  input  logic [SampleW-1:0] top_i,
  input  logic [SampleW-1:0] mask_i,
  output logic               ready_o,
  output logic               we_o,
  output logic [AddrW-1:0]   waddr_o,
  output logic [SampleW-1:0] wdata_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [SampleW-1:0] pixel_o
);

  logic                s1_valid_q;
  lppu_info_t          s1_info_q;
  logic [SampleW-1:0]  s1_res_q;
  logic [AddrW-1:0]    s1_addr_q;
  logic [SampleW-1:0]  left_q, above_q;
  logic                out_valid_q;
  logic [SampleW-1:0]  pixel_q;

  logic                fire;
  logic [SampleW-1:0]  l, a, t, lo, hi, pred, pix;
  logic signed [SampleW+1:0] grad;

  assign fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign ready_o = !s1_valid_q || fire;

  always_comb begin
    l    = s1_info_q.first ? '0 : left_q;
    a    = s1_info_q.first ? '0 : above_q;
    t    = s1_info_q.vertical ? top_i : '0;
    lo   = (l < t) ? l : t;
    hi   = (l < t) ? t : l;
    grad = $signed({2'b00, l}) + $signed({2'b00, t}) - $signed({2'b00, a});
    if (grad < $signed({2'b00, lo})) begin
      pred = lo;
    end else if (grad > $signed({2'b00, hi})) begin
      pred = hi;
    end else begin
      pred = grad[SampleW-1:0];
    end

    if (s1_info_q.mode == PredNone) begin
      pix = s1_res_q & mask_i;
    end else if (s1_info_q.col_zero) begin
      pix = (t + s1_res_q) & mask_i;
    end else if (!s1_info_q.vertical || s1_info_q.mode == PredLeft) begin
      pix = (l + s1_res_q) & mask_i;
    end else if (s1_info_q.mode == PredGradient) begin
      pix = (l + t - a + s1_res_q) & mask_i;
    end else begin
      pix = (pred + s1_res_q) & mask_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      left_q      <= '0;
      above_q     <= '0;
    end else begin
      if (load_i) begin
        s1_valid_q <= 1'b1;
      end else if (fire) begin
        s1_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
        left_q      <= pix;
        above_q     <= t;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      s1_info_q <= info_i;
      s1_res_q  <= residual_i;
      s1_addr_q <= waddr_i;
    end
    if (fire) begin
      pixel_q <= pix;
    end
  end

  assign we_o        = fire;
  assign waddr_o     = s1_addr_q;
  assign wdata_o     = pix;
  assign out_valid_o = out_valid_q;
  assign pixel_o     = pixel_q;

endmodule

/* sim/lppu_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lppu_checker
// Watches the register port and both streams of the prediction undo core,
// rebuilds every pixel from its own copy of the line store, position and
// registers, and compares each output item with the oldest expected pixel.
// ----------------------------------------------------------------------------
module lppu_checker
  import lppu_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [15:0]         s_axis_tdata,   // residual[11:0], zero pad
  input  logic [2:0]          s_axis_tuser,   // first_of_slice[0], pred_mode[2:1]
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [15:0]         m_axis_tdata,   // pixel[11:0], zero pad
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output int                  pending_o,
  output int                  errors_o
);

  bit   [SampleW-1:0]     row_mem [2*MAX_WIDTH];
  int unsigned            col_pos;
  int unsigned            rows_finished;
  bit                     cur_slot;
  int                     left_px;
  int                     diag_px;
  pred_mode_e             slice_mode;
  logic [LineWidthW-1:0]  width_q;
  logic [SampleBitsW-1:0] bits_q;
  logic                   interleave_q;
  logic [SampleW-1:0]     expected_pixels [$];
  logic [SampleW-1:0]     want_px;
  int                     queued = 0;
  int                     mismatch_count = 0;

  assign pending_o = queued;
  assign errors_o  = mismatch_count;

  function automatic logic [SampleW-1:0] rebuild_pixel(int res, bit first, pred_mode_e mode);
    int unsigned eff_width;
    int unsigned eff_bits;
    int unsigned col;
    int          mask;
    int          top;
    int          grad;
    int          lo;
    int          hi;
    int          pred;
    int          pix;
    bit          vertical;
    bit          src;
    eff_bits  = (bits_q > 12) ? 12 : bits_q;
    mask      = (1 << eff_bits) - 1;
    eff_width = width_q;
    if (eff_width == 0) eff_width = 1;
    if (eff_width > MAX_WIDTH) eff_width = MAX_WIDTH;
    if (first) begin
      col_pos       = 0;
      rows_finished = 0;
      cur_slot      = 1'b0;
      left_px       = 0;
      diag_px       = 0;
      slice_mode    = mode;
    end
    col      = col_pos % MAX_WIDTH;
    vertical = rows_finished >= 1 + interleave_q;
    src      = interleave_q ? cur_slot : ~cur_slot;
    top      = vertical ? int'(row_mem[src * MAX_WIDTH + col]) : 0;
    if (slice_mode == PredNone) begin
      pix = res;
    end else if (col == 0) begin
      pix = top + res;
    end else if (!vertical || slice_mode == PredLeft) begin
      pix = left_px + res;
    end else if (slice_mode == PredGradient) begin
      pix = left_px + top - diag_px + res;
    end else begin
      grad = left_px + top - diag_px;
      lo   = (left_px < top) ? left_px : top;
      hi   = (left_px < top) ? top : left_px;
      pred = (grad < lo) ? lo : ((grad > hi) ? hi : grad);
      pix  = pred + res;
    end
    pix = pix & mask;
    row_mem[cur_slot * MAX_WIDTH + col] = pix[SampleW-1:0];
    left_px = pix;
    diag_px = top;
    if (col_pos + 1 >= eff_width) begin
      col_pos = 0;
      if (rows_finished < 2) rows_finished++;
      cur_slot = ~cur_slot;
    end else begin
      col_pos++;
    end
    return pix[SampleW-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_pos       = 0;
      rows_finished = 0;
      cur_slot      = 1'b0;
      left_px       = 0;
      diag_px       = 0;
      slice_mode    = PredNone;
      width_q       = 4096;
      bits_q        = 10;
      interleave_q  = 1'b0;
      expected_pixels.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgLineWidth:       width_q      = cfg_wdata_i[LineWidthW-1:0];
          CfgSampleBits:      bits_q       = cfg_wdata_i[SampleBitsW-1:0];
          CfgFieldInterleave: interleave_q = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected output item, pixel %h", $time, m_axis_tdata[SampleW-1:0]);
          mismatch_count++;
        end else begin
          want_px = expected_pixels.pop_front();
          if (m_axis_tdata[SampleW-1:0] !== want_px) begin
            $display("%0t: pixel mismatch, expected %h, got %h", $time, want_px,
                     m_axis_tdata[SampleW-1:0]);
            mismatch_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_pixels.push_back(rebuild_pixel(int'(s_axis_tdata[SampleW-1:0]),
                                                s_axis_tuser[0],
                                                pred_mode_e'(s_axis_tuser[2:1])));
      end
    end
    queued = expected_pixels.size();
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives residual items and register settings into the prediction undo core
// with random gaps and output stalls, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top
  import lppu_pkg::*;
;

  localparam int unsigned MaxWidth    = 4096;
  localparam int unsigned RandomItems = 1580;
  localparam int unsigned HoldAt      = 600;
  localparam int unsigned HoldCycles  = 400;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [15:0]         s_axis_tdata  = '0;
  logic [2:0]          s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [15:0]         m_axis_tdata;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_wdata_i   = '0;

  int pending_results;
  int fail_count;
  bit burst_phase     = 1'b0;
  int items_sent      = 0;
  int settings_used   = 0;
  int results_seen    = 0;
  int slices_by_mode [4] = '{0, 0, 0, 0};

  always #1 clk_i = ~clk_i;

  lossless_pixel_prediction_undo_core #(
    .MAX_WIDTH(MaxWidth)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  lppu_checker #(
    .MAX_WIDTH(MaxWidth)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .pending_o    (pending_results),
    .errors_o     (fail_count)
  );

  task automatic send_item(logic [SampleW-1:0] res, bit first, pred_mode_e mode);
    int gap;
    gap = burst_phase ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, res};
    s_axis_tuser  <= {mode, first};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    if (first) slices_by_mode[mode]++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [CfgDataW-1:0] line_w, logic [CfgDataW-1:0] bits,
                           logic [CfgDataW-1:0] interleave);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgLineWidth;
    cfg_wdata_i <= line_w;
    @(posedge clk_i);
    cfg_idx_i   <= CfgSampleBits;
    cfg_wdata_i <= bits;
    @(posedge clk_i);
    cfg_idx_i   <= CfgFieldInterleave;
    cfg_wdata_i <= interleave;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    settings_used++;
  endtask

  // Each setting opens a new slice, so the line store is only read where this
  // slice has already written it.
  task automatic run_slices(int line_w, int bits, bit interleave, int count, bit noisy);
    bit first;
    wait_idle();
    write_cfg(CfgDataW'(line_w), CfgDataW'(bits), CfgDataW'(interleave));
    burst_phase = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < count; i++) begin
      first = (i == 0) || (noisy ? ($urandom_range(0, 7) == 0) : ($urandom_range(0, 199) == 0));
      send_item(SampleW'($urandom_range(0, 4095)), first, pred_mode_e'($urandom_range(0, 3)));
    end
  endtask

  initial begin : stimulus
    logic [SampleW-1:0] edge_res [5];
    int rand_items;
    int line_w;
    int bits;
    int eff_w;
    int count;
    edge_res   = '{12'h000, 12'hFFF, 12'hFFF, 12'h001, 12'h800};
    rand_items = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Before any slice start the residuals pass through, masked to ten bits.
    send_item(12'hFFF, 1'b0, PredLeft);
    send_item(12'h000, 1'b0, PredMedian);
    send_item(12'h3A5, 1'b0, PredGradient);
    wait_idle();
    write_cfg(CfgDataW'(2), CfgDataW'(12), CfgDataW'(0));
    for (int m = 0; m < 4; m++) begin
      for (int k = 0; k < 5; k++) send_item(edge_res[k], k == 0, pred_mode_e'(m));
    end
    run_slices(8191, 15, 1'b1, 30, 1'b0);
    run_slices(MaxWidth, 11, 1'b0, 40, 1'b0);
    run_slices(0, 0, 1'b1, 12, 1'b1);
    run_slices(1, 12, 1'b0, 12, 1'b0);
    while (rand_items < RandomItems) begin
      case ($urandom_range(0, 19))
        0:       line_w = 0;
        1:       line_w = $urandom_range(MaxWidth + 1, 8191);
        2, 3:    line_w = $urandom_range(17, 300);
        default: line_w = $urandom_range(1, 16);
      endcase
      bits  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(10, 12);
      eff_w = (line_w == 0) ? 1 : line_w;
      if (line_w > MaxWidth) count = $urandom_range(5, 40);
      else count = eff_w * $urandom_range(1, 5) + $urandom_range(0, eff_w);
      if (count > int'(RandomItems) - rand_items) count = int'(RandomItems) - rand_items;
      run_slices(line_w, bits, 1'($urandom_range(0, 1)), count, $urandom_range(0, 9) == 0);
      rand_items += count;
    end
    wait_idle();
    repeat (8) @(posedge clk_i);
    $display("Run covered %0d items over %0d register settings; slices none/left/gradient/median:",
             items_sent, settings_used);
    $display("  %0d/%0d/%0d/%0d, progressive and interlaced, widths 0 to 8191, long output stall.",
             slices_by_mode[0], slices_by_mode[1], slices_by_mode[2], slices_by_mode[3]);
    if (fail_count == 0 && pending_results == 0) begin
      $display("lossless_pixel_prediction_undo_core test passed");
    end else begin
      $display("lossless_pixel_prediction_undo_core test failed");
    end
    $finish;
  end

  initial begin : result_sink
    int stall;
    bit held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = burst_phase ? 0 : $urandom_range(0, 13);
      if (results_seen == HoldAt && !held) begin
        held  = 1'b1;
        stall = HoldCycles;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      results_seen++;
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("lossless_pixel_prediction_undo_core test failed");
    $finish;
  end

endmodule
